>>> sv/aabb_all_pairs_overlap_count_top_macros.svh
//------------------------------------------------------------------------------
// aabb_all_pairs_overlap_count_top_macros.svh
// Assertion macros for the box overlap counter.
//------------------------------------------------------------------------------
`ifndef AABB_ALL_PAIRS_OVERLAP_COUNT_TOP_MACROS_SVH
`define AABB_ALL_PAIRS_OVERLAP_COUNT_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
// clocked implication, reset-qualified
`define AAPOC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("aapoc assertion failed");
// same, with a caller message
`define AAPOC_ASSERT_MSG(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);
`else
`define AAPOC_ASSERT(lbl, prop)
`define AAPOC_ASSERT_MSG(lbl, prop, msg)
`endif

`endif

>>> sv/aapoc_pkg.sv
//------------------------------------------------------------------------------
// aapoc_pkg
// Types and constants shared by the box overlap counter modules.
//------------------------------------------------------------------------------
package aapoc_pkg;

    localparam int COORD_W = 32;
    localparam int CNT_W   = 15;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    typedef struct packed {
        logic signed [COORD_W-1:0] min_x;
        logic signed [COORD_W-1:0] min_y;
        logic signed [COORD_W-1:0] min_z;
        logic signed [COORD_W-1:0] max_x;
        logic signed [COORD_W-1:0] max_y;
        logic signed [COORD_W-1:0] max_z;
        logic                      last_box;
    } in_item_t;

    typedef struct packed {
        logic [CNT_W-1:0] pair_checks;
        logic [CNT_W-1:0] overlap_pairs;
        logic             set_overflow;
    } out_item_t;

    // controller -> datapath
    typedef struct packed {
        logic load;     // store the accepted box
        logic issue;    // launch current (i,j) pair into the compare pipe
        logic publish;  // move counters to the output register, clear set
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic few;       // fewer than two boxes stored
        logic pair_last; // current (i,j) is the final pair
        logic busy;      // compare pipe holds work
        logic out_full;  // output register holds an unsent item
    } status_t;

endpackage

>>> sv/aabb_all_pairs_overlap_count_top.sv
// Result: a set's item is published after the sweep, once the compare pipe has
//   drained, and it waits while the output slot still holds an unsent item.
// Throughput: one box per cycle while loading; the sweep runs one pair per cycle on
//   the two read ports of the box store, so no box is taken during it.
// Reset: aresetn is synchronous, active low; it empties the set and the output slot.
//   The box store itself is not cleared: only entries written in this set are read.
//------------------------------------------------------------------------------
// aabb_all_pairs_overlap_count_top
// Brute-force 3D axis-aligned box pair overlap counter.
//------------------------------------------------------------------------------
`include "aabb_all_pairs_overlap_count_top_macros.svh"

module aabb_all_pairs_overlap_count_top
    import aapoc_pkg::*;
#(
    parameter int MAX_BOXES = 256   // store depth, 2 .. 4096
) (
    input  logic      aclk,
    input  logic      aresetn,
    // box items
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_item,
    // result items
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    // Structure:
    //   ctrl - LOAD takes boxes; the box marked last_box moves to SWEEP, which
    //          launches one (i,j) pair per cycle, i<j, row by row; DRAIN waits for
    //          the compare pipe to empty and the output slot to free, then hands over the counts.
    //   dp   - box store (write on load, two registered reads), compare stage,
    //          saturating 15-bit counters and the output register.
    // The output register lets loading of the next set start while a result
    // is still waiting for m_ready.

    cmd_t    cmd;
    status_t stat;

    aapoc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_last  (s_item.last_box),
        .s_ready (s_ready),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    aapoc_dp #(
        .MAX_BOXES (MAX_BOXES)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_item  (s_item),
        .m_ready (m_ready),
        .cmd     (cmd),
        .stat    (stat),
        .m_valid (m_valid),
        .m_item  (m_item)
    );

    // pairs are only launched while input is held off
    `AAPOC_ASSERT(a_issue_no_load, cmd.issue |-> !s_ready)
    // counts move out only once the compare pipe is empty
    `AAPOC_ASSERT(a_publish_drained, cmd.publish |-> !stat.busy)
    // a published count shows up as a valid item next cycle
    `AAPOC_ASSERT_MSG(a_publish_valid, cmd.publish |=> m_valid, "result not presented")
    // overlapping pairs never exceed pairs tested
    `AAPOC_ASSERT_MSG(a_ovl_le_chk, m_valid |-> (m_item.overlap_pairs <= m_item.pair_checks),
        "overlap count above pair count")

endmodule

>>> sv/aapoc_ctrl.sv
//------------------------------------------------------------------------------
// aapoc_ctrl
// Load / sweep / drain sequencer for the box overlap counter.
//------------------------------------------------------------------------------
module aapoc_ctrl
    import aapoc_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    input  logic    s_last,
    output logic    s_ready,
    input  logic    m_ready,
    input  status_t stat,
    output cmd_t    cmd
);

    localparam logic [1:0] S_LOAD  = 2'd0;
    localparam logic [1:0] S_SWEEP = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign s_ready = (state_reg == S_LOAD);

    always_comb begin
        state_next  = state_reg;
        cmd.load    = 1'b0;
        cmd.issue   = 1'b0;
        cmd.publish = 1'b0;
        unique case (state_reg)
            S_LOAD: begin
                if (s_valid) begin
                    cmd.load = 1'b1;
                    if (s_last) begin
                        state_next = S_SWEEP;
                    end
                end
            end
            S_SWEEP: begin
                if (stat.few) begin
                    state_next = S_DRAIN;
                end else begin
                    cmd.issue = 1'b1;
                    if (stat.pair_last) begin
                        state_next = S_DRAIN;
                    end
                end
            end
            S_DRAIN: begin
                // wait for the pipe to empty and the output slot to free up
                if (!stat.busy && (!stat.out_full || m_ready)) begin
                    cmd.publish = 1'b1;
                    state_next  = S_LOAD;
                end
            end
            default: begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

>>> sv/aapoc_dp.sv
//------------------------------------------------------------------------------
// aapoc_dp
// Box store, pair address counters, overlap compare pipe and counters.
//------------------------------------------------------------------------------
module aapoc_dp
    import aapoc_pkg::*;
#(
    parameter int MAX_BOXES = 256
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  in_item_t  s_item,
    input  logic      m_ready,
    input  cmd_t      cmd,
    output status_t   stat,
    output logic      m_valid,
    output out_item_t m_item
);

    localparam int AW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int CW = $clog2(MAX_BOXES + 1);

    typedef struct packed {
        logic signed [COORD_W-1:0] min_x;
        logic signed [COORD_W-1:0] min_y;
        logic signed [COORD_W-1:0] min_z;
        logic signed [COORD_W-1:0] max_x;
        logic signed [COORD_W-1:0] max_y;
        logic signed [COORD_W-1:0] max_z;
    } box_t;

    function automatic logic boxes_overlap(input box_t a, input box_t b);
        logic hit;
        hit = (a.min_x <= b.max_x) && (b.min_x <= a.max_x) &&
              (a.min_y <= b.max_y) && (b.min_y <= a.max_y) &&
              (a.min_z <= b.max_z) && (b.min_z <= a.max_z);
        return hit;
    endfunction

    box_t box_mem [MAX_BOXES];
    box_t wr_box;
    box_t rd_a_reg;
    box_t rd_b_reg;

    logic [CW-1:0]    n_reg;
    logic             ovf_reg;
    logic [AW-1:0]    i_reg;
    logic [AW-1:0]    j_reg;
    logic             v1_reg;
    logic             v2_reg;
    logic             hit_reg;
    logic [CNT_W-1:0] chk_reg;
    logic [CNT_W-1:0] ovl_reg;
    logic             out_valid_reg;
    out_item_t        out_item_reg;
    logic             room;
    logic             j_end;

    assign wr_box = '{min_x: s_item.min_x, min_y: s_item.min_y, min_z: s_item.min_z,
                      max_x: s_item.max_x, max_y: s_item.max_y, max_z: s_item.max_z};

    assign room  = (n_reg < CW'(MAX_BOXES));
    assign j_end = ((CW'(j_reg) + CW'(1)) == n_reg);

    assign stat.few       = (n_reg < CW'(2));
    assign stat.pair_last = j_end && ((CW'(i_reg) + CW'(2)) == n_reg);
    assign stat.busy      = v1_reg || v2_reg;
    assign stat.out_full  = out_valid_reg;

    assign m_valid = out_valid_reg;
    assign m_item  = out_item_reg;

    // store: one write port, two registered read ports
    always_ff @(posedge aclk) begin
        if (cmd.load && room) begin
            box_mem[n_reg[AW-1:0]] <= wr_box;
        end
        rd_a_reg <= box_mem[i_reg];
        rd_b_reg <= box_mem[j_reg];
    end

    always_ff @(posedge aclk) begin
        hit_reg <= boxes_overlap(rd_a_reg, rd_b_reg);
        if (cmd.publish) begin
            out_item_reg <= '{pair_checks: chk_reg, overlap_pairs: ovl_reg,
                              set_overflow: ovf_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_reg         <= '0;
            ovf_reg       <= 1'b0;
            i_reg         <= '0;
            j_reg         <= AW'(1);
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            chk_reg       <= '0;
            ovl_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            v1_reg <= cmd.issue;
            v2_reg <= v1_reg;

            if (cmd.load) begin
                if (room) begin
                    n_reg <= n_reg + CW'(1);
                end else begin
                    ovf_reg <= 1'b1;
                end
            end

            // walk j to the end of the row, then start the next row at i+2
            if (cmd.issue) begin
                if (j_end) begin
                    i_reg <= i_reg + AW'(1);
                    j_reg <= i_reg + AW'(2);
                end else begin
                    j_reg <= j_reg + AW'(1);
                end
            end

            if (v2_reg) begin
                if (chk_reg != CNT_MAX) begin
                    chk_reg <= chk_reg + CNT_W'(1);
                end
                if (hit_reg && (ovl_reg != CNT_MAX)) begin
                    ovl_reg <= ovl_reg + CNT_W'(1);
                end
            end

            if (cmd.publish) begin
                n_reg   <= '0;
                ovf_reg <= 1'b0;
                i_reg   <= '0;
                j_reg   <= AW'(1);
                chk_reg <= '0;
                ovl_reg <= '0;
            end

            if (cmd.publish) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule
